/* rtl/hgpl_pkg.sv */
// hgpl_pkg: grid geometry constants, divider reciprocals and stage structs
// for the hex grid point locator; no dependencies
`timescale 1ns / 1ps

package hgpl_pkg;

  // grid geometry
  localparam int SIDE_LEN    = 24;
  localparam int SLANT_LEN   = 12;
  localparam int CELL_HEIGHT = 40;
  localparam int COORD_BITS  = 12;

  // fixed width of every payload field on the ports
  localparam int FIELD_W = 12;

  localparam int HALF_HEIGHT = CELL_HEIGHT / 2;
  localparam int COL_PITCH   = SIDE_LEN + SLANT_LEN;

  // internal widths
  localparam int CW    = COORD_BITS;
  localparam int ROW_W = CW + 1;
  localparam int X0_W  = CW + $clog2(COL_PITCH + 1) + 1;
  localparam int XC_W  = X0_W + 1;
  localparam int Y0_W  = ROW_W + $clog2(CELL_HEIGHT + 1);
  localparam int D_W   = $clog2(CELL_HEIGHT + 1);
  localparam int DH_W  = $clog2(HALF_HEIGHT + 1);
  localparam int R_W   = $clog2(SLANT_LEN + 1);

  // exact floor division by a constant: n * ceil(2^s / k) >> s, s = N + clog2(k)
  localparam int     PX_SH  = CW + $clog2(COL_PITCH);
  localparam longint PX_M   = ((longint'(1) << PX_SH) + COL_PITCH - 1) / COL_PITCH;
  localparam int     PX_P_W = CW + CW + 2;

  localparam int     RY_SH  = CW + $clog2(CELL_HEIGHT);
  localparam longint RY_M   = ((longint'(1) << RY_SH) + CELL_HEIGHT - 1) / CELL_HEIGHT;
  localparam int     RY_P_W = CW + CW + 2;

  // slant reach = SLANT_LEN * d / HALF_HEIGHT folded into one constant multiply
  localparam int     NUM_W  = $clog2(SLANT_LEN * HALF_HEIGHT + 1);
  localparam int     RH_SH  = NUM_W + $clog2(HALF_HEIGHT);
  localparam longint RH_M   = ((longint'(1) << RH_SH) + HALF_HEIGHT - 1) / HALF_HEIGHT;
  localparam longint RH_K   = SLANT_LEN * RH_M;
  localparam int     RH_P_W = DH_W + NUM_W + 2 + R_W;

  // first guess of column and the two row quotients
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] gc;
    logic [CW-1:0] q_even;
    logic [CW-1:0] q_odd;
  } guess_t;

  // three candidates: col[0]/x0[0] for the first, col[1]/x0[1] for the others
  typedef struct packed {
    logic [CW-1:0]              x;
    logic [1:0][CW-1:0]         col;
    logic [2:0][ROW_W-1:0]      row;
    logic [2:0]                 ok;
    logic [2:0][DH_W-1:0]       d;
    logic [1:0][X0_W-1:0]       x0;
  } cand_t;

endpackage

/* rtl/hex_grid_point_locator.sv */
// hex_grid_point_locator: top level, finds the hexagon of a column-offset
// flat-sided hex grid that holds a screen point; uses hgpl_pkg, hgpl_guess,
// hgpl_geom and hgpl_test
`timescale 1ns / 1ps

// usage
//   slave channel: one point per item, tdata = {point_y, point_x}
//   master channel: one result per point, tdata = {hex_row, hex_column},
//     tuser = found; a point outside every candidate gives column 0, row 0,
//     found 0
//   result timing: a result shows on m_axis_tvalid from the output register
//     once its point has passed every stage, later only while the receiver stalls
//   throughput: one point per cycle unless the receiver stalls; five register stages
//     (guess, corners, band test, slant reach, output) all move together
//   stall: while a result waits with m_axis_tready low the whole pipeline
//     holds and s_axis_tready drops; nothing is lost or repeated, and
//     s_axis_tready returns in the same cycle that m_axis_tready does
//   reset: rst_ni clears every stage valid bit at once, the block takes
//     items from the first cycle after reset; there is no other state
//   stages: the column guess and both row quotients are exact reciprocal
//     multiplies, the slant reach is one constant multiply; the guess multiplies
//     sit side by side in the guess stage, the reach ones in the reach stage

module hex_grid_point_locator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [2*hgpl_pkg::FIELD_W-1:0] s_axis_tdata,  // point_x, point_y
  // master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [2*hgpl_pkg::FIELD_W-1:0] m_axis_tdata,  // hex_column, hex_row
  output logic                           m_axis_tuser   // found
);

  logic                         en;
  logic                         guess_valid;
  hgpl_pkg::guess_t             guess;
  logic                         cand_valid;
  hgpl_pkg::cand_t              cand;
  logic [hgpl_pkg::FIELD_W-1:0] hex_column;
  logic [hgpl_pkg::FIELD_W-1:0] hex_row;
  logic [hgpl_pkg::CW-1:0]      point_x;
  logic [hgpl_pkg::CW-1:0]      point_y;

  // whole pipeline advances unless a finished result is blocked
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // coordinates are taken modulo the coordinate range
  assign point_x = hgpl_pkg::CW'(s_axis_tdata[hgpl_pkg::FIELD_W-1:0]);
  assign point_y = hgpl_pkg::CW'(s_axis_tdata[2*hgpl_pkg::FIELD_W-1:hgpl_pkg::FIELD_W]);

  hgpl_guess u_guess (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .x_i     (point_x),
    .y_i     (point_y),
    .valid_o (guess_valid),
    .guess_o (guess)
  );

  hgpl_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (guess_valid),
    .guess_i (guess),
    .valid_o (cand_valid),
    .cand_o  (cand)
  );

  hgpl_test u_test (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (cand_valid),
    .cand_i   (cand),
    .valid_o  (m_axis_tvalid),
    .column_o (hex_column),
    .row_o    (hex_row),
    .found_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {hex_row, hex_column};

endmodule

/* rtl/hgpl_guess.sv */
// hgpl_guess: first pipeline stage, guesses column and row quotients
// by reciprocal multiplication; depends on hgpl_pkg
`timescale 1ns / 1ps

module hgpl_guess (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [hgpl_pkg::CW-1:0] x_i,
  input  logic [hgpl_pkg::CW-1:0] y_i,
  output logic                    valid_o,
  output hgpl_pkg::guess_t        guess_o
);

  logic [hgpl_pkg::CW-1:0]     nx;
  logic [hgpl_pkg::CW-1:0]     ny_odd;
  logic [hgpl_pkg::PX_P_W-1:0] px_prod;
  logic [hgpl_pkg::RY_P_W-1:0] ry_even;
  logic [hgpl_pkg::RY_P_W-1:0] ry_odd;
  hgpl_pkg::guess_t            guess_d;
  hgpl_pkg::guess_t            guess_q;
  logic                        valid_q;

  assign nx      = x_i - hgpl_pkg::CW'(hgpl_pkg::SLANT_LEN);
  assign ny_odd  = y_i - hgpl_pkg::CW'(hgpl_pkg::HALF_HEIGHT);
  assign px_prod = hgpl_pkg::PX_P_W'(nx) * hgpl_pkg::PX_P_W'(hgpl_pkg::PX_M);
  assign ry_even = hgpl_pkg::RY_P_W'(y_i) * hgpl_pkg::RY_P_W'(hgpl_pkg::RY_M);
  assign ry_odd  = hgpl_pkg::RY_P_W'(ny_odd) * hgpl_pkg::RY_P_W'(hgpl_pkg::RY_M);

  always_comb begin
    guess_d.x = x_i;
    guess_d.y = y_i;
    // left margin falls into column 0
    if (hgpl_pkg::X0_W'(x_i) < hgpl_pkg::X0_W'(hgpl_pkg::COL_PITCH)) begin
      guess_d.gc = '0;
    end else begin
      guess_d.gc = hgpl_pkg::CW'(px_prod >> hgpl_pkg::PX_SH);
    end
    guess_d.q_even = hgpl_pkg::CW'(ry_even >> hgpl_pkg::RY_SH);
    // odd columns near the top truncate toward zero
    if (y_i < hgpl_pkg::CW'(hgpl_pkg::HALF_HEIGHT)) begin
      guess_d.q_odd = '0;
    end else begin
      guess_d.q_odd = hgpl_pkg::CW'(ry_odd >> hgpl_pkg::RY_SH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      guess_q <= guess_d;
    end
  end

  assign valid_o = valid_q;
  assign guess_o = guess_q;

endmodule

/* rtl/hgpl_geom.sv */
// hgpl_geom: two pipeline stages, candidate cells with their corners,
// then vertical band test and mirrored height; depends on hgpl_pkg
`timescale 1ns / 1ps

module hgpl_geom (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  hgpl_pkg::guess_t guess_i,
  output logic             valid_o,
  output hgpl_pkg::cand_t  cand_o
);

  typedef struct packed {
    logic [hgpl_pkg::CW-1:0]              x;
    logic [hgpl_pkg::CW-1:0]              y;
    logic [1:0][hgpl_pkg::CW-1:0]         col;
    logic [2:0][hgpl_pkg::ROW_W-1:0]      row;
    logic [2:0]                           ok;
    logic [2:0][hgpl_pkg::Y0_W-1:0]       y0;
    logic [1:0][hgpl_pkg::X0_W-1:0]       x0;
  } corner_t;

  logic [hgpl_pkg::ROW_W-1:0] gr;
  logic [hgpl_pkg::X0_W-1:0]  x0_base;
  corner_t                    corner_d;
  corner_t                    corner_q;
  logic                       corner_valid_q;
  hgpl_pkg::cand_t            cand_d;
  hgpl_pkg::cand_t            cand_q;
  logic                       cand_valid_q;
  logic [hgpl_pkg::Y0_W-1:0]  y_ext;
  logic [hgpl_pkg::D_W-1:0]   dy [3];
  logic [2:0]                 in_band;

  // stage a: candidate cells, lower-left corners
  always_comb begin
    gr = guess_i.gc[0] ? {guess_i.q_odd, 1'b1} : {guess_i.q_even, 1'b0};
    x0_base = hgpl_pkg::X0_W'(hgpl_pkg::SLANT_LEN)
            + hgpl_pkg::X0_W'(guess_i.gc) * hgpl_pkg::X0_W'(hgpl_pkg::COL_PITCH);

    corner_d.x      = guess_i.x;
    corner_d.y      = guess_i.y;
    corner_d.col[0] = guess_i.gc;
    corner_d.col[1] = guess_i.gc + 1'b1;
    corner_d.row[0] = gr;
    corner_d.row[1] = gr + 1'b1;
    corner_d.row[2] = gr - 1'b1;
    // row 0 of an odd column and negative rows do not exist
    corner_d.ok[0] = !(corner_d.col[0][0] && (corner_d.row[0] == '0));
    corner_d.ok[1] = !(corner_d.col[1][0] && (corner_d.row[1] == '0));
    corner_d.ok[2] = (gr != '0) && !(corner_d.col[1][0] && (corner_d.row[2] == '0));
    for (int k = 0; k < 3; k++) begin
      corner_d.y0[k] = hgpl_pkg::Y0_W'((hgpl_pkg::Y0_W'(corner_d.row[k])
                     * hgpl_pkg::Y0_W'(hgpl_pkg::CELL_HEIGHT)) >> 1);
    end
    corner_d.x0[0] = x0_base;
    corner_d.x0[1] = x0_base + hgpl_pkg::X0_W'(hgpl_pkg::COL_PITCH);
  end

  // stage b: vertical band and height mirrored about the middle
  always_comb begin
    y_ext = hgpl_pkg::Y0_W'(corner_q.y);
    cand_d.x   = corner_q.x;
    cand_d.col = corner_q.col;
    cand_d.row = corner_q.row;
    cand_d.x0  = corner_q.x0;
    for (int k = 0; k < 3; k++) begin
      in_band[k] = (y_ext >= corner_q.y0[k])
                && (y_ext <= corner_q.y0[k] + hgpl_pkg::Y0_W'(hgpl_pkg::CELL_HEIGHT));
      dy[k] = hgpl_pkg::D_W'(y_ext - corner_q.y0[k]);
      if (dy[k] <= hgpl_pkg::D_W'(hgpl_pkg::HALF_HEIGHT)) begin
        cand_d.d[k] = hgpl_pkg::DH_W'(dy[k]);
      end else begin
        cand_d.d[k] = hgpl_pkg::DH_W'(hgpl_pkg::D_W'(hgpl_pkg::CELL_HEIGHT) - dy[k]);
      end
    end
    cand_d.ok = corner_q.ok & in_band;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_valid_q <= 1'b0;
      cand_valid_q   <= 1'b0;
    end else if (en_i) begin
      corner_valid_q <= valid_i;
      cand_valid_q   <= corner_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      corner_q <= corner_d;
      cand_q   <= cand_d;
    end
  end

  assign valid_o = cand_valid_q;
  assign cand_o  = cand_q;

endmodule

/* rtl/hgpl_test.sv */
// hgpl_test: slant reach stage, then horizontal test, first-hit select
// and the output register; depends on hgpl_pkg
`timescale 1ns / 1ps

module hgpl_test (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  hgpl_pkg::cand_t              cand_i,
  output logic                         valid_o,
  output logic [hgpl_pkg::FIELD_W-1:0] column_o,
  output logic [hgpl_pkg::FIELD_W-1:0] row_o,
  output logic                         found_o
);

  typedef struct packed {
    logic [hgpl_pkg::CW-1:0]              x;
    logic [1:0][hgpl_pkg::CW-1:0]         col;
    logic [2:0][hgpl_pkg::ROW_W-1:0]      row;
    logic [2:0]                           ok;
    logic [1:0][hgpl_pkg::X0_W-1:0]       x0;
    logic [2:0][hgpl_pkg::R_W-1:0]        reach;
  } reach_t;

  reach_t                        reach_d;
  reach_t                        reach_q;
  logic                          reach_valid_q;
  logic [hgpl_pkg::RH_P_W-1:0]   rh_prod [3];
  logic [hgpl_pkg::XC_W-1:0]     x0_k [3];
  logic [hgpl_pkg::XC_W-1:0]     x_ext;
  logic [2:0]                    hit;
  logic [hgpl_pkg::FIELD_W-1:0]  column_d;
  logic [hgpl_pkg::FIELD_W-1:0]  row_d;
  logic [hgpl_pkg::FIELD_W-1:0]  column_q;
  logic [hgpl_pkg::FIELD_W-1:0]  row_q;
  logic                          found_q;
  logic                          out_valid_q;

  // stage c: horizontal reach of the slanted edges
  always_comb begin
    reach_d.x   = cand_i.x;
    reach_d.col = cand_i.col;
    reach_d.row = cand_i.row;
    reach_d.ok  = cand_i.ok;
    reach_d.x0  = cand_i.x0;
    for (int k = 0; k < 3; k++) begin
      rh_prod[k] = hgpl_pkg::RH_P_W'(cand_i.d[k]) * hgpl_pkg::RH_P_W'(hgpl_pkg::RH_K);
      reach_d.reach[k] = hgpl_pkg::R_W'(rh_prod[k] >> hgpl_pkg::RH_SH);
    end
  end

  // stage d: left and right edge test, first candidate that holds wins
  always_comb begin
    x_ext   = hgpl_pkg::XC_W'(reach_q.x);
    x0_k[0] = hgpl_pkg::XC_W'(reach_q.x0[0]);
    x0_k[1] = hgpl_pkg::XC_W'(reach_q.x0[1]);
    x0_k[2] = hgpl_pkg::XC_W'(reach_q.x0[1]);
    for (int k = 0; k < 3; k++) begin
      hit[k] = reach_q.ok[k]
            && (x_ext + hgpl_pkg::XC_W'(reach_q.reach[k]) >= x0_k[k])
            && (x_ext <= x0_k[k] + hgpl_pkg::XC_W'(hgpl_pkg::SIDE_LEN)
                        + hgpl_pkg::XC_W'(reach_q.reach[k]));
    end
    if (hit[0]) begin
      column_d = hgpl_pkg::FIELD_W'(reach_q.col[0]);
      row_d    = hgpl_pkg::FIELD_W'(reach_q.row[0]);
    end else if (hit[1]) begin
      column_d = hgpl_pkg::FIELD_W'(reach_q.col[1]);
      row_d    = hgpl_pkg::FIELD_W'(reach_q.row[1]);
    end else if (hit[2]) begin
      column_d = hgpl_pkg::FIELD_W'(reach_q.col[1]);
      row_d    = hgpl_pkg::FIELD_W'(reach_q.row[2]);
    end else begin
      column_d = '0;
      row_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else if (en_i) begin
      reach_valid_q <= valid_i;
      out_valid_q   <= reach_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      reach_q  <= reach_d;
      column_q <= column_d;
      row_q    <= row_d;
      found_q  <= |hit;
    end
  end

  assign valid_o  = out_valid_q;
  assign column_o = column_q;
  assign row_o    = row_q;
  assign found_o  = found_q;

endmodule

/* rtl/hgpl_checker.sv */
// hgpl_checker: port-level assertions for hex_grid_point_locator and the
// bind that attaches them; depends on hgpl_pkg
`timescale 1ns / 1ps

module hgpl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_i,
  input logic                           m_axis_tvalid_i,
  input logic                           m_axis_tready_i,
  input logic [2*hgpl_pkg::FIELD_W-1:0] m_axis_tdata_i,
  input logic                           m_axis_tuser_i
);

  // input side is open exactly when no result is blocked
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_i == (!m_axis_tvalid_i || m_axis_tready_i))
    else $error("s_axis_tready does not follow the output stall");

  // a blocked result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("blocked result changed");

  // a miss reports column 0 and row 0
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tuser_i |-> m_axis_tdata_i == '0)
    else $error("miss with nonzero column or row");

  // doubled rows: odd columns use odd rows, even columns even rows
  a_row_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i |->
      m_axis_tdata_i[0] == m_axis_tdata_i[hgpl_pkg::FIELD_W])
    else $error("row parity does not match column parity");

endmodule

bind hex_grid_point_locator hgpl_checker u_hgpl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata),
  .m_axis_tuser_i  (m_axis_tuser)
);
